// ===== rtl/sog_pkg.sv =====
`timescale 1ns / 1ps

package sog_pkg;

  // fixed field widths
  localparam int FREQ_IN_W = 24;   // Q16.8 Hz
  localparam int FREQ_W    = 40;   // Q16.24 Hz
  localparam int VOL_W     = 16;
  localparam int LEN_IN_W  = 13;
  localparam int SAMPLE_W  = 16;
  localparam int MAG_W     = 15;
  localparam int SCALE_W   = 36;
  localparam int SPLIT_W   = 18;   // step scale is multiplied in two halves
  localparam int PROD_W    = FREQ_IN_W + SPLIT_W;
  localparam int TOTAL_W   = FREQ_IN_W + SCALE_W;
  localparam int TUNE_SHIFT = 24;
  localparam int MIX_W     = MAG_W + VOL_W;

  // stream packing
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 36'd5864062015;
  localparam logic [VOL_W-1:0]   VOL_ONE     = 16'h8000;

  // table generation constants
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210, 64'd272};

  // commands from the controller
  typedef struct packed {
    logic latch;
    logic rom_rd;
    logic load_direct;
    logic load_target;
    logic clear_left;
    logic div_start;
    logic ramp_load;
    logic glide_step;
    logic mul_lo;
    logic mul_hi;
    logic tune;
    logic mix;
    logic emit;
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic op_direct;
    logic block_start;
    logic ramp_needed;
    logic left_nz;
    logic div_done;
    logic out_free;
  } stat_t;

  // quarter-wave sine entry, evaluated at elaboration
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                    input int unsigned addr_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint s;
    x = (longint'(k) * HALF_PI_Q30) >> (addr_bits - 2);
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if ((n & 1) == 1) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    v = (longint'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

// ===== rtl/sog_sine_rom.sv =====
`timescale 1ns / 1ps

module sog_sine_rom import sog_pkg::*; #(
  parameter int ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] addr_i,
  output logic [MAG_W-1:0]  mag_o,
  output logic              neg_o
);

  localparam int QW = ADDR_W - 2;
  localparam int QDEPTH = (1 << QW) + 1;
  localparam logic [QW:0] QUARTER_K = {1'b1, {QW{1'b0}}};

  logic [MAG_W-1:0] qtab [QDEPTH];
  logic [QW:0]      k;
  logic [MAG_W-1:0] mag_q;
  logic             neg_q;

  // quarter wave constants
  for (genvar i = 0; i < QDEPTH; i++) begin : g_tab
    localparam logic [MAG_W-1:0] VAL = quarter_sine(i, ADDR_W);
    assign qtab[i] = VAL;
  end

  // fold the address into the first quarter
  always_comb begin
    if (addr_i[ADDR_W-2]) begin
      k = QUARTER_K - {1'b0, addr_i[QW-1:0]};
    end else begin
      k = {1'b0, addr_i[QW-1:0]};
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mag_q <= qtab[k];
      neg_q <= addr_i[ADDR_W-1];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

// ===== rtl/sog_divider.sv =====
`timescale 1ns / 1ps

module sog_divider #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] dvd_q, dvd_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DEN_W:0]   shl;
  logic [DEN_W+1:0] sub;

  // one quotient bit per cycle, restoring
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    shl    = {rem_q, dvd_q[NUM_W-1]};
    sub    = {1'b0, shl} - {2'b00, den_q};
    if (start_i) begin
      dvd_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        if (!sub[DEN_W+1]) begin
          rem_d = sub[DEN_W-1:0];
          dvd_d = {dvd_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_d = shl[DEN_W-1:0];
          dvd_d = {dvd_q[NUM_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = dvd_q;

endmodule

// ===== rtl/sog_datapath.sv =====
`timescale 1ns / 1ps

module sog_datapath import sog_pkg::*; #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int MAX_BLOCK       = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output stat_t                      stat_o,
  input  logic                       op_i,
  input  logic [FREQ_IN_W-1:0]       frequency_i,
  input  logic [VOL_W-1:0]           volume_i,
  input  logic                       block_start_i,
  input  logic [LEN_IN_W-1:0]        block_length_i,
  input  logic                       cfg_valid_i,
  input  logic [SCALE_W-1:0]         cfg_data_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [SAMPLE_W-1:0] sample_o
);

  localparam int LEN_W = $clog2(MAX_BLOCK + 1);

  // latched item
  logic                 op_q;
  logic [FREQ_IN_W-1:0] freq_q;
  logic [VOL_W-1:0]     vol_q;
  logic                 start_q;
  logic [LEN_W-1:0]     len_q;
  logic [VOL_W-1:0]     vol_sat;
  logic [LEN_W-1:0]     len_eff;

  // oscillator state
  logic [PHASE_BITS-1:0] phase_q;
  logic [PHASE_BITS-1:0] tuning_q;
  logic [FREQ_W-1:0]     cur_q;
  logic [FREQ_W-1:0]     step_q;
  logic [FREQ_IN_W-1:0]  target_q;
  logic [LEN_W-1:0]      left_q;
  logic [SCALE_W-1:0]    scale_q;

  // work registers
  logic [PROD_W-1:0]     acc_lo_q;
  logic [PROD_W-1:0]     acc_hi_q;
  logic [TOTAL_W-1:0]    total;
  logic [MIX_W-1:0]      prod_q;
  logic                  div_neg_q;
  logic                  out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q;

  logic [FREQ_W-1:0]     freq_ext;
  logic [FREQ_W-1:0]     tgt_ext;
  logic signed [FREQ_W:0] diff;
  logic [FREQ_W-1:0]     diff_mag;
  logic [FREQ_W-1:0]     quot;
  logic                  div_done;
  logic [MAG_W-1:0]      rom_mag;
  logic                  rom_neg;
  logic [SAMPLE_W-1:0]   mag16;

  // input conditioning
  always_comb begin
    vol_sat = (volume_i > VOL_ONE) ? VOL_ONE : volume_i;
    if (block_length_i == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(block_length_i) > MAX_BLOCK) begin
      len_eff = LEN_W'(MAX_BLOCK);
    end else begin
      len_eff = LEN_W'(block_length_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= op_i;
      freq_q  <= frequency_i;
      vol_q   <= vol_sat;
      start_q <= block_start_i;
      len_q   <= len_eff;
    end
  end

  // glide difference and its magnitude
  assign freq_ext = {freq_q, 16'h0000};
  assign tgt_ext  = {target_q, 16'h0000};
  assign diff     = $signed({1'b0, freq_ext}) - $signed({1'b0, cur_q});
  assign diff_mag = diff[FREQ_W] ? FREQ_W'(-diff) : diff[FREQ_W-1:0];

  sog_divider #(
    .NUM_W (FREQ_W),
    .DEN_W (LEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (diff_mag),
    .den_i   (len_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  sog_sine_rom #(
    .ADDR_W (TABLE_ADDR_BITS)
  ) u_rom (
    .clk_i   (clk_i),
    .rd_en_i (cmd_i.rom_rd),
    .addr_i  (phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
    .mag_o   (rom_mag),
    .neg_o   (rom_neg)
  );

  // step scale register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_valid_i) begin
      scale_q <= cfg_data_i;
    end
  end

  // frequency and ramp state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      step_q    <= '0;
      target_q  <= '0;
      left_q    <= '0;
      div_neg_q <= 1'b0;
    end else begin
      if (cmd_i.load_direct) begin
        cur_q  <= freq_ext;
        left_q <= '0;
      end
      if (cmd_i.load_target) begin
        target_q <= freq_q;
      end
      if (cmd_i.clear_left) begin
        left_q <= '0;
      end
      if (cmd_i.div_start) begin
        div_neg_q <= diff[FREQ_W];
      end
      if (cmd_i.ramp_load) begin
        step_q <= div_neg_q ? (~quot + 1'b1) : quot;
        left_q <= len_q;
      end
      if (cmd_i.glide_step) begin
        if (left_q == LEN_W'(1)) begin
          cur_q <= tgt_ext;
        end else begin
          cur_q <= cur_q + step_q;
        end
        left_q <= left_q - 1'b1;
      end
    end
  end

  // tuning word in two partial products
  assign total = {acc_hi_q, {SPLIT_W{1'b0}}} + {{SPLIT_W{1'b0}}, acc_lo_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      acc_lo_q <= PROD_W'(cur_q[FREQ_W-1 -: FREQ_IN_W]) * PROD_W'(scale_q[SPLIT_W-1:0]);
    end
    if (cmd_i.mul_hi) begin
      acc_hi_q <= PROD_W'(cur_q[FREQ_W-1 -: FREQ_IN_W])
                  * PROD_W'(scale_q[SCALE_W-1:SPLIT_W]);
    end
    if (cmd_i.mix) begin
      prod_q <= MIX_W'(rom_mag) * MIX_W'(vol_q);
    end
  end

  // tuning word and phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tuning_q <= '0;
      phase_q  <= '0;
    end else begin
      if (cmd_i.tune) begin
        tuning_q <= PHASE_BITS'(total >> TUNE_SHIFT);
      end
      if (cmd_i.emit) begin
        phase_q <= phase_q + tuning_q;
      end
    end
  end

  // output register
  assign mag16 = prod_q[MIX_W-1 -: SAMPLE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      sample_q <= rom_neg ? $signed(-mag16) : $signed(mag16);
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  // status
  assign stat_o.op_direct   = op_q;
  assign stat_o.block_start = start_q;
  assign stat_o.ramp_needed = (freq_ext != cur_q);
  assign stat_o.left_nz     = (left_q != '0);
  assign stat_o.div_done    = div_done;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  // checks
  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= LEN_W'(MAX_BLOCK))
    else $error("samples left above block limit");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites a waiting beat");

  a_glide_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.glide_step |-> (left_q != '0))
    else $error("glide step with no ramp pending");

  a_ramp_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ramp_load |-> div_done)
    else $error("ramp loaded before divide finished");

endmodule

// ===== rtl/sog_ctrl.sv =====
`timescale 1ns / 1ps

module sog_ctrl import sog_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_GLIDE  = 4'd3;
  localparam logic [3:0] S_MUL_LO = 4'd4;
  localparam logic [3:0] S_MUL_HI = 4'd5;
  localparam logic [3:0] S_TUNE   = 4'd6;
  localparam logic [3:0] S_MIX    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0] state_q, state_d;

  // sequencing of one item
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.rom_rd = 1'b1;
        if (stat_i.op_direct) begin
          cmd_o.load_direct = 1'b1;
          state_d           = S_MUL_LO;
        end else if (stat_i.block_start) begin
          cmd_o.load_target = 1'b1;
          if (stat_i.ramp_needed) begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end else begin
            cmd_o.clear_left = 1'b1;
            state_d          = S_MIX;
          end
        end else if (stat_i.left_nz) begin
          state_d = S_GLIDE;
        end else begin
          state_d = S_MIX;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.ramp_load = 1'b1;
          state_d         = S_GLIDE;
        end
      end
      S_GLIDE: begin
        cmd_o.glide_step = 1'b1;
        state_d          = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_TUNE;
      end
      S_TUNE: begin
        cmd_o.tune = 1'b1;
        state_d    = S_MIX;
      end
      S_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== rtl/sine_oscillator_with_glide_core.sv =====
// sequence: steady glide goes from decide to mix and emit; a direct frequency
//   adds multiply and tune, a glide step also a glide, a ramp start also a divide
// throughput: one item at a time, next beat taken the cycle after the result is
//   registered; the ramp start is set by the 40-step serial divider
// reset: asynchronous, clears phase, tuning word, frequency and ramp state, and
//   loads the default step scale; the sine table is constant and needs no fill
`timescale 1ns / 1ps

module sine_oscillator_with_glide_core import sog_pkg::*; #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int MAX_BLOCK       = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // frequency[23:0], volume[39:24],
                                                // block_length[52:40]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // op[0], block_start[1]
  // master stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // sample[15:0]
  // step scale write
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [SCALE_W-1:0]     cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;
  logic signed [SAMPLE_W-1:0] sample;

  sog_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sog_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .MAX_BLOCK       (MAX_BLOCK)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (s_axis_tuser[0]),
    .frequency_i    (s_axis_tdata[23:0]),
    .volume_i       (s_axis_tdata[39:24]),
    .block_start_i  (s_axis_tuser[1]),
    .block_length_i (s_axis_tdata[52:40]),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .sample_o       (sample)
  );

  assign m_axis_tdata = OUT_TDATA_W'(sample);
  assign cfg_ready_o  = 1'b1;

endmodule
